// File: rtl/ncomix_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncomix_pkg: shared types, constants and table math for the NCO mixer
// Holds the register index codes, the sample word type, the sine table
// generator used at elaboration and the divide-by-full-scale with saturation.
// ----------------------------------------------------------------------------
package ncomix_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIX_ENABLE = 1'd1;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   localparam longint unsigned FULL_SCALE = 64'd32767;
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint          ONE_Q30    = 64'd1073741824;

   typedef struct packed {
      logic                          mix;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } sample_type;

   // Unsigned quotient by shift and subtract; used only while building the table.
   function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave sine, Q30 Taylor series to x^15, rounded to Q15 scale.
   function automatic longint quarter_sine(longint unsigned r, int abits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned den;
      longint          sum;
      x    = (r * TWO_PI_Q30) >> abits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         den  = longint'(2 * k) * longint'(2 * k + 1);
         term = udiv((term * x2) >> 30, den);
         if ((k & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      return longint'(((longint'(sum) * FULL_SCALE) + longint'(ONE_Q30 / 2)) >> 30);
   endfunction

   // One entry of the full sine table of 2^abits entries.
   function automatic logic signed [SAMPLE_BITS-1:0] sine_entry(longint unsigned addr,
                                                                  int abits);
      longint unsigned n;
      longint unsigned qlen;
      longint unsigned quad;
      longint unsigned r;
      longint          mag;
      n    = longint'(1) << abits;
      qlen = n >> 2;
      quad = (addr & (n - 1)) >> (abits - 2);
      r    = addr & (qlen - 1);
      if ((quad & 1) != 0) begin
         r = qlen - r;
      end
      mag = quarter_sine(r, abits);
      if ((quad & 2) != 0) begin
         mag = -mag;
      end
      return SAMPLE_BITS'(mag);
   endfunction

   // Divide by 32767 truncating toward zero, then saturate to 16 bits.
   // m = a*2^15 + b = a*32767 + (a + b); fold once more and correct once.
   function automatic logic signed [SAMPLE_BITS-1:0] div_sat(logic signed [32:0] v);
      logic [32:0] mag_full;
      logic [31:0] m;
      logic [17:0] t;
      logic [15:0] u;
      logic [17:0] q;
      logic signed [SAMPLE_BITS-1:0] res;
      mag_full = v[32] ? 33'(-v) : 33'(v);
      m        = mag_full[31:0];
      t        = 18'(m[31:15]) + 18'(m[14:0]);
      u        = 16'(t[17:15]) + 16'(t[14:0]);
      q        = 18'(m[31:15]) + 18'(t[17:15]) + ((u >= 16'd32767) ? 18'd1 : 18'd0);
      if (!v[32]) begin
         res = (q > 18'd32767) ? 16'sh7FFF : SAMPLE_BITS'(q);
      end else begin
         res = (q > 18'd32768) ? 16'sh8000 : SAMPLE_BITS'(18'(-q));
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// File: rtl/ncomix_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncomix_front: input acceptance, register file and phase accumulator
// Takes a sample word, advances the phase when mixing, and pushes the sample
// with its mix flag and sine table address into the queue.
// ----------------------------------------------------------------------------
module ncomix_front #(
   parameter int PHASE_BITS     = 16,
   parameter int SINE_ADDR_BITS = 10
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_stall,
   input  wire  signed [ncomix_pkg::SAMPLE_BITS-1:0]   req_in_real,
   input  wire  signed [ncomix_pkg::SAMPLE_BITS-1:0]   req_in_imag,
   input  wire                                         csr_write,
   input  wire         [ncomix_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire         [ncomix_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  wire                                         queue_full,
   output logic                                        push,
   output ncomix_pkg::sample_type                      push_sample,
   output logic        [SINE_ADDR_BITS-1:0]            push_addr
);

   logic [15:0]             phase_step_ff;
   logic                    mix_enable_ff;
   logic [PHASE_BITS-1:0]   phase_ff;
   logic [PHASE_BITS-1:0]   phase_in;
   logic [PHASE_BITS+15:0]  step_cat;
   logic [PHASE_BITS-1:0]   step_aligned;
   logic                    accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept;

   // Align step so one unit is 2^-16 turn: top PHASE_BITS of step * 2^PHASE_BITS / 2^16.
   assign step_cat     = {phase_step_ff, {PHASE_BITS{1'b0}}};
   assign step_aligned = step_cat[PHASE_BITS+15:16];
   assign phase_in     = phase_ff + step_aligned;

   generate
      if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_top
         assign push_addr = phase_in[PHASE_BITS-1 -: SINE_ADDR_BITS];
      end else begin : g_addr_pad
         assign push_addr = {phase_in, {(SINE_ADDR_BITS-PHASE_BITS){1'b0}}};
      end
   endgenerate

   assign push_sample.mix = mix_enable_ff;
   assign push_sample.re  = req_in_real;
   assign push_sample.im  = req_in_imag;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         mix_enable_ff <= 1'b0;
         phase_ff      <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               ncomix_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_wdata[15:0];
               ncomix_pkg::CSR_MIX_ENABLE: mix_enable_ff <= csr_wdata[0];
               default:                    phase_step_ff <= phase_step_ff;
            endcase
         end
         // advance only on a mixed word
         if (accept && mix_enable_ff) begin
            phase_ff <= phase_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !mix_enable_ff |=> $stable(phase_ff))
      else $error("phase moved on a pass-through word");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      accept && mix_enable_ff |=> phase_ff == $past(phase_in))
      else $error("phase did not advance by the step");
`endif

endmodule
`default_nettype wire

// File: rtl/ncomix_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncomix_queue: short FIFO between front and back
// Lets the front keep taking words while the back is held by the output.
// ----------------------------------------------------------------------------
module ncomix_queue #(
   parameter int WIDTH = 43
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire  [WIDTH-1:0]  push_data,
   input  wire               pop,
   output logic [WIDTH-1:0]  pop_data,
   output logic              not_empty,
   output logic              full
);

   logic [WIDTH-1:0]                           mem_ff [ncomix_pkg::QUEUE_DEPTH];
   logic [ncomix_pkg::QUEUE_PTR_BITS-1:0]      wr_ptr_ff;
   logic [ncomix_pkg::QUEUE_PTR_BITS-1:0]      rd_ptr_ff;
   logic [ncomix_pkg::QUEUE_CNT_BITS-1:0]      count_ff;

   assign full      = (count_ff == ncomix_pkg::QUEUE_CNT_BITS'(ncomix_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire

// File: rtl/ncomix_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncomix_back: sine lookup, complex multiply, scale and saturate
// Four register stages with a stall chain: table read, products, sums,
// divide by full scale with saturation into the output register.
// ----------------------------------------------------------------------------
module ncomix_back #(
   parameter int SINE_ADDR_BITS = 10
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        q_valid,
   input  ncomix_pkg::sample_type                     q_sample,
   input  wire         [SINE_ADDR_BITS-1:0]           q_addr,
   output logic                                       q_pop,
   output logic                                       rsp_valid,
   input  wire                                        rsp_stall,
   output logic signed [ncomix_pkg::SAMPLE_BITS-1:0]  rsp_out_real,
   output logic signed [ncomix_pkg::SAMPLE_BITS-1:0]  rsp_out_imag
);

   localparam int ROM_DEPTH = 2 ** SINE_ADDR_BITS;
   localparam int QTR_TURN  = ROM_DEPTH / 4;

   typedef logic signed [ncomix_pkg::SAMPLE_BITS-1:0] rom_type [ROM_DEPTH];

   function automatic rom_type build_rom();
      rom_type t;
      for (int a = 0; a < ROM_DEPTH; a++) begin
         t[a] = ncomix_pkg::sine_entry(64'(a), SINE_ADDR_BITS);
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [SINE_ADDR_BITS-1:0] cos_addr;

   logic                   v1_ff, v2_ff, v3_ff;
   ncomix_pkg::sample_type s1_ff, s2_ff, s3_ff;
   logic signed [15:0]     sin1_ff, cos1_ff;
   logic signed [31:0]     p_ic_ff, p_qs_ff, p_qc_ff, p_is_ff;
   logic signed [32:0]     sum_re_ff, sum_im_ff;
   logic                   adv_out, adv3, adv2, adv1;

   assign cos_addr = q_addr + SINE_ADDR_BITS'(QTR_TURN);

   assign adv_out = !rsp_valid || !rsp_stall;
   assign adv3    = !v3_ff || adv_out;
   assign adv2    = !v2_ff || adv3;
   assign adv1    = !v1_ff || adv2;
   assign q_pop   = q_valid && adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= q_pop;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (adv_out) begin
            rsp_valid <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ff   <= q_sample;
         sin1_ff <= SINE_ROM[q_addr];
         cos1_ff <= SINE_ROM[cos_addr];
      end
      if (adv2) begin
         s2_ff   <= s1_ff;
         p_ic_ff <= s1_ff.re * cos1_ff;
         p_qs_ff <= s1_ff.im * sin1_ff;
         p_qc_ff <= s1_ff.im * cos1_ff;
         p_is_ff <= s1_ff.re * sin1_ff;
      end
      if (adv3) begin
         s3_ff     <= s2_ff;
         sum_re_ff <= 33'(p_ic_ff) + 33'(p_qs_ff);
         sum_im_ff <= 33'(p_qc_ff) - 33'(p_is_ff);
      end
      if (adv_out) begin
         rsp_out_real <= s3_ff.mix ? ncomix_pkg::div_sat(sum_re_ff) : s3_ff.re;
         rsp_out_imag <= s3_ff.mix ? ncomix_pkg::div_sat(sum_im_ff) : s3_ff.im;
      end
   end

endmodule
`default_nettype wire

// File: rtl/nco_complex_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nco_complex_mixer: complex down-conversion mixer with NCO
// Multiplies each I/Q word by exp(-j*phase) from a sine table, scaled by
// full scale 32767 and saturated; passes words through when mixing is off.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_in_real, req_in_imag
//  rsp       out        rsp_valid/rsp_stall  rsp_out_real, rsp_out_imag
//  csr       in         csr_write            csr_index, csr_wdata
//
// One word per clock sustained while rsp_stall is low. An accepted word passes
// through the queue, table read, products, sums, and divide and saturate.
// The phase adder in the front is the only loop.
// Reset clears the phase, the registers, the queue and all stage valids;
// the sine table is a constant ROM, so no fill pass follows reset.
// A stalled output holds the back stages; the front keeps taking words until
// the 4-entry queue fills, then raises req_stall.
// ----------------------------------------------------------------------------
module nco_complex_mixer #(
   parameter int PHASE_BITS     = 16,
   parameter int SINE_ADDR_BITS = 10
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          req_valid,
   output logic                                         req_stall,
   input  wire  signed [ncomix_pkg::SAMPLE_BITS-1:0]    req_in_real,
   input  wire  signed [ncomix_pkg::SAMPLE_BITS-1:0]    req_in_imag,
   output logic                                         rsp_valid,
   input  wire                                          rsp_stall,
   output logic signed [ncomix_pkg::SAMPLE_BITS-1:0]    rsp_out_real,
   output logic signed [ncomix_pkg::SAMPLE_BITS-1:0]    rsp_out_imag,
   input  wire                                          csr_write,
   input  wire         [ncomix_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire         [ncomix_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int SAMPLE_W = $bits(ncomix_pkg::sample_type);
   localparam int ENTRY_W  = SAMPLE_W + SINE_ADDR_BITS;

   // front to queue
   logic                        push;
   ncomix_pkg::sample_type      push_sample;
   logic [SINE_ADDR_BITS-1:0]   push_addr;
   logic                        queue_full;

   // queue to back
   logic [ENTRY_W-1:0]          pop_data;
   logic                        q_valid;
   logic                        q_pop;
   ncomix_pkg::sample_type      q_sample;
   logic [SINE_ADDR_BITS-1:0]   q_addr;

   ncomix_front #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_real (req_in_real),
      .req_in_imag (req_in_imag),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_full  (queue_full),
      .push        (push),
      .push_sample (push_sample),
      .push_addr   (push_addr)
   );

   // word in the queue: table address above the sample
   ncomix_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_addr, push_sample}),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .not_empty (q_valid),
      .full      (queue_full)
   );

   assign q_sample = ncomix_pkg::sample_type'(pop_data[SAMPLE_W-1:0]);
   assign q_addr   = pop_data[ENTRY_W-1:SAMPLE_W];

   ncomix_back #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_sample     (q_sample),
      .q_addr       (q_addr),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_real (rsp_out_real),
      .rsp_out_imag (rsp_out_imag)
   );

endmodule
`default_nettype wire
